>>> hw/rtl/looped_wavetable_player_assert.svh
// ----------------------------------------------------------------------------
// Looped wavetable player assertion macros
// Shared property templates for the checker of the looped wavetable player.
// ----------------------------------------------------------------------------
`ifndef LOOPED_WAVETABLE_PLAYER_ASSERT_SVH
`define LOOPED_WAVETABLE_PLAYER_ASSERT_SVH

// Check expr in the same cycle as cond.
`define LWP_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Check expr in the cycle after cond.
`define LWP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> hw/rtl/lwp_pkg.sv
// ----------------------------------------------------------------------------
// Looped wavetable player package
// Field widths, command and register codes, reset values and shared structs.
// ----------------------------------------------------------------------------
package lwp_pkg;

   localparam int FRAC_BITS           = 16;
   localparam int TABLE_DEPTH_DEFAULT = 4096;
   localparam int MIN_LOOP            = 16;
   localparam int MIN_LOOP_LOG2       = 4;

   localparam int CMD_W          = 2;
   localparam int TABLE_ADDR_W   = 12;
   localparam int SAMPLE_W       = 16;
   localparam int SHIFT_W        = 29;
   localparam int ANGLE_W        = 16;
   localparam int LOOP_LENGTH_W  = 13;
   localparam int RATE_W         = 20;
   localparam int OFFSET_W       = 28;

   localparam int REG_W          = 2;
   localparam int CSR_ADDR_W     = REG_W + 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [REG_W-1:0] REG_LOOP_LENGTH  = 2'd0;
   localparam logic [REG_W-1:0] REG_RATE         = 2'd1;
   localparam logic [REG_W-1:0] REG_PHASE_OFFSET = 2'd2;

   localparam logic [LOOP_LENGTH_W-1:0] LOOP_LENGTH_RESET  = 13'd4096;
   localparam logic [RATE_W-1:0]        RATE_RESET         = 20'd65536;
   localparam logic [OFFSET_W-1:0]      PHASE_OFFSET_RESET = 28'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_TIME  = 2'd2,
      CMD_PHASE = 2'd3
   } lwp_cmd_type;

   typedef enum logic {
      ST_RUN,
      ST_REDUCE
   } lwp_state_type;

   typedef struct packed {
      logic [LOOP_LENGTH_W-1:0] loop_length;
      logic [RATE_W-1:0]        rate;
      logic [OFFSET_W-1:0]      phase_offset;
   } lwp_cfg_type;

   // One tick handed from the address stage to the interpolation stage.
   typedef struct packed {
      logic                 valid;
      logic                 interp;
      logic [FRAC_BITS-1:0] frac;
   } lwp_issue_type;

endpackage

>>> hw/rtl/lwp_csr.sv
// ----------------------------------------------------------------------------
// Looped wavetable player register file
// APB-style access to loop length, rate and phase offset.
// ----------------------------------------------------------------------------
module lwp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lwp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lwp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lwp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output lwp_pkg::lwp_cfg_type             cfg,
   output logic                             loop_wr
);
   import lwp_pkg::*;

   logic [LOOP_LENGTH_W-1:0] loop_length_ff, loop_length_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [OFFSET_W-1:0]      phase_offset_ff, phase_offset_in;
   logic [REG_W-1:0]         reg_idx;
   logic                     wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign loop_wr    = wr_en && (reg_idx == REG_LOOP_LENGTH);

   always_comb begin
      loop_length_in  = loop_length_ff;
      rate_in         = rate_ff;
      phase_offset_in = phase_offset_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LOOP_LENGTH:  loop_length_in  = csr_pwdata[LOOP_LENGTH_W-1:0];
            REG_RATE:         rate_in         = csr_pwdata[RATE_W-1:0];
            REG_PHASE_OFFSET: phase_offset_in = csr_pwdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_length_ff  <= LOOP_LENGTH_RESET;
         rate_ff         <= RATE_RESET;
         phase_offset_ff <= PHASE_OFFSET_RESET;
      end else begin
         loop_length_ff  <= loop_length_in;
         rate_ff         <= rate_in;
         phase_offset_ff <= phase_offset_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LOOP_LENGTH:  csr_prdata = CSR_DATA_W'(loop_length_ff);
         REG_RATE:         csr_prdata = CSR_DATA_W'(rate_ff);
         REG_PHASE_OFFSET: csr_prdata = CSR_DATA_W'(phase_offset_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.loop_length  = loop_length_ff;
   assign cfg.rate         = rate_ff;
   assign cfg.phase_offset = phase_offset_ff;

endmodule

>>> hw/rtl/lwp_table.sv
// ----------------------------------------------------------------------------
// Looped wavetable player sample memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module lwp_table #(
   parameter int TABLE_DEPTH = lwp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
   input  logic signed [lwp_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr0,
   input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr1,
   output logic signed [lwp_pkg::SAMPLE_W-1:0]  rd_data0,
   output logic signed [lwp_pkg::SAMPLE_W-1:0]  rd_data1
);
   import lwp_pkg::*;

   logic signed [SAMPLE_W-1:0] mem_ff [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data0_ff;
   logic signed [SAMPLE_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> hw/rtl/lwp_position.sv
// ----------------------------------------------------------------------------
// Looped wavetable player position stage
// Input register, play position, table addressing and loop reduction pass.
// ----------------------------------------------------------------------------
module lwp_position #(
   parameter int TABLE_DEPTH = lwp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lwp_pkg::lwp_cfg_type                   cfg,
   input  logic                                   loop_wr,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [lwp_pkg::CMD_W-1:0]              req_cmd,
   input  logic [lwp_pkg::TABLE_ADDR_W-1:0]       req_table_addr,
   input  logic signed [lwp_pkg::SAMPLE_W-1:0]    req_table_sample,
   input  logic signed [lwp_pkg::SHIFT_W-1:0]     req_time_shift,
   input  logic [lwp_pkg::ANGLE_W-1:0]            req_phase_angle,
   input  logic                                   b_ready,
   output lwp_pkg::lwp_issue_type                 issue,
   output logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr0,
   output logic [$clog2(TABLE_DEPTH)-1:0]         rd_addr1,
   output logic                                   wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]         wr_addr,
   output logic signed [lwp_pkg::SAMPLE_W-1:0]    wr_data
);
   import lwp_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int LW    = $clog2(TABLE_DEPTH + 1);
   localparam int PW    = LW + FRAC_BITS;
   localparam int LCW   = (LW > LOOP_LENGTH_W) ? LW : LOOP_LENGTH_W;
   localparam int OCW   = (PW > OFFSET_W) ? PW : OFFSET_W;
   localparam int TCW   = (PW > SHIFT_W) ? PW : SHIFT_W;
   localparam int ACW   = (AW + 1 > TABLE_ADDR_W) ? AW + 1 : TABLE_ADDR_W;
   localparam int RW    = PW + LW;
   localparam int MAXSH = LW - MIN_LOOP_LOG2;
   localparam int SW    = $clog2(LW);

   // Add two values below m and wrap once.
   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b,
                                              input logic [PW-1:0] m);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[PW-1:0];
   endfunction

   lwp_state_type state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [PW-1:0] pos_ff, pos_in;

   logic                       a_vld_ff, a_vld_in;
   lwp_cmd_type                a_cmd_ff;
   logic [TABLE_ADDR_W-1:0]    a_addr_ff;
   logic signed [SAMPLE_W-1:0] a_sample_ff;
   logic signed [SHIFT_W-1:0]  a_shift_ff;
   logic [ANGLE_W-1:0]         a_angle_ff;
   logic                       a_fire;
   logic                       req_take;

   logic [LCW-1:0] loop_raw;
   logic [LW-1:0]  loop_n;
   logic [PW-1:0]  lf, lf_m1;
   logic [OCW-1:0] off_ext;
   logic [PW-1:0]  off_c, read_pos;
   logic [LW-1:0]  k, k_inc, k1;
   logic [SHIFT_W-1:0] shift_bits, mag_raw;
   logic [TCW-1:0] mag_ext;
   logic [PW-1:0]  mag_c, shift_neg_pos, shift_pos;
   logic [PW-1:0]  phase_add, phase_pos, tick_pos;
   logic [RW-1:0]  lf_sh, pos_ext;
   logic [PW-1:0]  pos_red;

   // Effective loop length, clamped between MIN_LOOP and the table depth.
   assign loop_raw = LCW'(cfg.loop_length);
   always_comb begin
      if (loop_raw < LCW'(MIN_LOOP)) begin
         loop_n = LW'(MIN_LOOP);
      end else if (loop_raw > LCW'(TABLE_DEPTH)) begin
         loop_n = LW'(TABLE_DEPTH);
      end else begin
         loop_n = LW'(loop_raw);
      end
   end
   assign lf    = {loop_n, {FRAC_BITS{1'b0}}};
   assign lf_m1 = lf - PW'(1);

   // Read position: clamp the offset below the loop, then add.
   assign off_ext  = OCW'(cfg.phase_offset);
   assign off_c    = (off_ext > OCW'(lf_m1)) ? lf_m1 : PW'(off_ext);
   assign read_pos = wrap_add(pos_ff, off_c, lf);
   assign k        = read_pos[PW-1:FRAC_BITS];
   assign k_inc    = k + LW'(1);
   assign k1       = (k_inc == loop_n) ? '0 : k_inc;

   // Time shift: magnitude clamp, then one wrap either way.
   assign shift_bits    = $unsigned(a_shift_ff);
   assign mag_raw       = shift_bits[SHIFT_W-1] ? (~shift_bits + SHIFT_W'(1)) : shift_bits;
   assign mag_ext       = TCW'(mag_raw);
   assign mag_c         = (mag_ext > TCW'(lf_m1)) ? lf_m1 : PW'(mag_ext);
   assign shift_neg_pos = (pos_ff >= mag_c) ? (pos_ff - mag_c)
                        : PW'({1'b0, pos_ff} + {1'b0, lf} - {1'b0, mag_c});
   assign shift_pos     = shift_bits[SHIFT_W-1] ? shift_neg_pos : wrap_add(pos_ff, mag_c, lf);

   // Phase shift: loop times angle stays below the loop.
   assign phase_add = PW'(loop_n) * PW'(a_angle_ff);
   assign phase_pos = wrap_add(pos_ff, phase_add, lf);

   assign tick_pos = wrap_add(pos_ff, PW'(cfg.rate), lf);

   // One remainder step per cycle of the reduction pass.
   assign lf_sh   = RW'(lf) << step_ff;
   assign pos_ext = RW'(pos_ff);
   assign pos_red = (pos_ext >= lf_sh) ? PW'(pos_ext - lf_sh) : pos_ff;

   assign a_fire   = a_vld_ff && ((a_cmd_ff != CMD_TICK) || b_ready);
   assign req_take = req_valid && req_ready;
   assign a_vld_in = req_take || (a_vld_ff && !a_fire);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_ready = !a_vld_ff || a_fire;
            if (a_fire) begin
               case (a_cmd_ff)
                  CMD_TICK:  pos_in = tick_pos;
                  CMD_TIME:  pos_in = shift_pos;
                  CMD_PHASE: pos_in = phase_pos;
                  default:   pos_in = pos_ff;
               endcase
            end
         end
         ST_REDUCE: begin
            pos_in = pos_red;
            if (step_ff == '0) begin
               state_in = ST_RUN;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         default: state_in = ST_RUN;
      endcase
      // Restart the pass on every loop length write.
      if (loop_wr) begin
         state_in = ST_REDUCE;
         step_in  = SW'(MAXSH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         step_ff  <= '0;
         pos_ff   <= '0;
         a_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_cmd_ff    <= lwp_cmd_type'(req_cmd);
         a_addr_ff   <= req_table_addr;
         a_sample_ff <= req_table_sample;
         a_shift_ff  <= req_time_shift;
         a_angle_ff  <= req_phase_angle;
      end
   end

   assign issue.valid  = a_fire && (a_cmd_ff == CMD_TICK);
   assign issue.interp = (cfg.rate[FRAC_BITS-1:0] != '0);
   assign issue.frac   = read_pos[FRAC_BITS-1:0];
   assign rd_addr0     = AW'(k);
   assign rd_addr1     = AW'(k1);

   // Drop loads beyond the table.
   assign wr_en   = a_fire && (a_cmd_ff == CMD_LOAD) && (ACW'(a_addr_ff) < ACW'(TABLE_DEPTH));
   assign wr_addr = AW'(a_addr_ff);
   assign wr_data = a_sample_ff;

endmodule

>>> hw/rtl/lwp_interp.sv
// ----------------------------------------------------------------------------
// Looped wavetable player interpolation stage
// Linear interpolation with round half up, and the result register.
// ----------------------------------------------------------------------------
module lwp_interp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lwp_pkg::lwp_issue_type               issue,
   input  logic signed [lwp_pkg::SAMPLE_W-1:0]  rd_data0,
   input  logic signed [lwp_pkg::SAMPLE_W-1:0]  rd_data1,
   output logic                                 b_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lwp_pkg::SAMPLE_W-1:0]  rsp_sample_out
);
   import lwp_pkg::*;

   localparam int DW         = SAMPLE_W + 1;
   localparam int PRODW      = SAMPLE_W + FRAC_BITS + 2;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   logic                       b_vld_ff, b_vld_in;
   logic                       interp_ff;
   logic [FRAC_BITS-1:0]       frac_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       b_fire;

   logic signed [DW-1:0]       diff;
   logic signed [PRODW-1:0]    prod;
   logic signed [PRODW-1:0]    rnd;
   logic [SAMPLE_W-1:0]        interp_val;
   logic signed [SAMPLE_W-1:0] result;

   assign b_fire       = b_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign b_ready      = !b_vld_ff || b_fire;
   assign b_vld_in     = issue.valid || (b_vld_ff && !b_fire);
   assign rsp_valid_in = b_fire || (rsp_valid_ff && !rsp_ready);

   assign diff       = DW'(rd_data1) - DW'(rd_data0);
   assign prod       = PRODW'(diff) * $signed({1'b0, frac_ff});
   assign rnd        = (prod + PRODW'(ROUND_HALF)) >>> FRAC_BITS;
   // The sum lies between the two entries, so the low bits are exact.
   assign interp_val = rd_data0 + rnd[SAMPLE_W-1:0];
   assign result     = interp_ff ? $signed(interp_val) : rd_data0;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_vld_ff     <= b_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         interp_ff <= issue.interp;
         frac_ff   <= issue.frac;
      end
      if (b_fire) begin
         rsp_sample_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

>>> hw/rtl/looped_wavetable_player.sv
// ----------------------------------------------------------------------------
// Looped wavetable player
// Looping sample-table oscillator with a Q13.16 play position and linear
// interpolation between neighboring entries.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per command: load a table sample, tick,
//   shift time or shift phase. Only a tick returns a transaction on rsp_*,
//   the sample at the play position plus phase offset, interpolated when
//   the rate has a fractional part.
//   csr_* holds loop_length (0x0), rate (0x4) and phase_offset (0x8).
//   Throughput: one transaction per cycle on req_*, any command mix, while
//   no reduction pass runs and no tick backs up. A tick passes the input
//   register, the registered table read and the output register behind
//   the multiply stage before its result shows on rsp_*.
//   Reset clears the play position, restores the register defaults and
//   empties the pipeline; table contents stay undefined until loaded.
//   A loop_length write starts a reduction pass that takes the position
//   modulo the new loop, one remainder step per cycle, from the largest
//   shift of the loop down to the loop itself; req_ready is low meanwhile.
//   When rsp_ready is low, the result holds in the output register, one
//   more tick waits in the interpolation stage and one in the input
//   register; loads and shifts keep flowing until a tick backs up.
// ----------------------------------------------------------------------------
module looped_wavetable_player #(
   parameter int TABLE_DEPTH = lwp_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command transactions
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lwp_pkg::CMD_W-1:0]            req_cmd,
   input  logic [lwp_pkg::TABLE_ADDR_W-1:0]     req_table_addr,
   input  logic signed [lwp_pkg::SAMPLE_W-1:0]  req_table_sample,
   input  logic signed [lwp_pkg::SHIFT_W-1:0]   req_time_shift,
   input  logic [lwp_pkg::ANGLE_W-1:0]          req_phase_angle,
   // sample transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lwp_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lwp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [lwp_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [lwp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import lwp_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   lwp_cfg_type   cfg;
   lwp_issue_type issue;
   logic          loop_wr;
   logic          b_ready;

   logic [AW-1:0]              rd_addr0;
   logic [AW-1:0]              rd_addr1;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic signed [SAMPLE_W-1:0] wr_data;
   logic signed [SAMPLE_W-1:0] rd_data0;
   logic signed [SAMPLE_W-1:0] rd_data1;

   // Registers; a loop length write also kicks the reduction pass.
   lwp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .loop_wr     (loop_wr)
   );

   // Stage one: hold the command, update the position, address the table.
   lwp_position #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_position (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .loop_wr          (loop_wr),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_table_addr   (req_table_addr),
      .req_table_sample (req_table_sample),
      .req_time_shift   (req_time_shift),
      .req_phase_angle  (req_phase_angle),
      .b_ready          (b_ready),
      .issue            (issue),
      .rd_addr0         (rd_addr0),
      .rd_addr1         (rd_addr1),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   // Read entry k and entry k+1 together; read data lands in stage two.
   lwp_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (issue.valid),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // Stage two: interpolate and hold the result until taken.
   lwp_interp u_interp (
      .clock          (clock),
      .reset          (reset),
      .issue          (issue),
      .rd_data0       (rd_data0),
      .rd_data1       (rd_data1),
      .b_ready        (b_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

>>> hw/rtl/lwp_checker.sv
// ----------------------------------------------------------------------------
// Looped wavetable player port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "looped_wavetable_player_assert.svh"

module lwp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [lwp_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [lwp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input logic [lwp_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   input logic [lwp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   input logic                                 csr_pready
);
   import lwp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] LOOP_ADDR = {REG_LOOP_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] RATE_ADDR = {REG_RATE, 2'b00};

   logic cfg_write;
   logic loop_write;
   logic rate_write;
   logic rate_read;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign loop_write = cfg_write && (csr_paddr == LOOP_ADDR);
   assign rate_write = cfg_write && (csr_paddr == RATE_ADDR);
   assign rate_read  = csr_psel && !csr_pwrite && (csr_paddr == RATE_ADDR);

   `LWP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out), "stalled sample transaction changed")
   `LWP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "pipeline not empty after reset")
   `LWP_ASSERT_NEXT(a_loop_reduce, clock, reset, loop_write, !req_ready, "commands accepted during loop reduction")
   `LWP_ASSERT_NOW(a_rate_readback, clock, reset, (rate_write ##1 rate_read), (csr_prdata[RATE_W-1:0] == $past(csr_pwdata[RATE_W-1:0])) && (csr_prdata[CSR_DATA_W-1:RATE_W] == '0), "rate readback mismatch")

endmodule

bind looped_wavetable_player lwp_checker u_lwp_checker (.*);
